>>> sv/yuv_to_rgb_color_converter_assert.svh
// Assertion macros shared by the YUV to RGB converter modules.
// Included by files that check their own pipeline logic; no dependencies.
`ifndef YUV_TO_RGB_COLOR_CONVERTER_ASSERT_SVH
`define YUV_TO_RGB_COLOR_CONVERTER_ASSERT_SVH

// same-cycle implication
`define YUVRGB_ASSERT_HOLDS(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("yuvrgb: assertion failed");

// next-cycle implication
`define YUVRGB_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("yuvrgb: assertion failed");

`endif

>>> sv/yuvrgb_pkg.sv
// Package for the YUV to RGB converter: widths, register codes, coefficient table
// and the payload types passed between pipeline modules. No dependencies.
package yuvrgb_pkg;

   localparam int COEF_FRAC_BITS  = 12;
   localparam int SAMPLE_WIDTH    = 16;
   localparam int COLOR_WIDTH     = 8;
   localparam int NUM_COLORS      = 3;
   localparam int NUM_TERMS       = 3;
   localparam int NUM_MATRICES    = 3;
   localparam int MIN_SAMPLE_BITS = 8;
   localparam int MAX_SAMPLE_BITS = 16;

   localparam int DIFF_WIDTH  = SAMPLE_WIDTH + 2;
   localparam int COEF_WIDTH  = COEF_FRAC_BITS + 3;
   localparam int PROD_WIDTH  = DIFF_WIDTH + COEF_WIDTH;
   localparam int SUM_WIDTH   = PROD_WIDTH + 2;
   localparam int DIV_WIDTH   = SAMPLE_WIDTH + COEF_FRAC_BITS;
   localparam int NUM_WIDTH   = DIV_WIDTH + COLOR_WIDTH;
   localparam int SHIFT_WIDTH = $clog2(MAX_SAMPLE_BITS - MIN_SAMPLE_BITS + 1);

   localparam int MODE_WIDTH      = 2;
   localparam int BITS_WIDTH      = 5;
   localparam int CSR_INDEX_WIDTH = 1;
   localparam int CSR_DATA_WIDTH  = BITS_WIDTH;

   localparam int IDX_RED   = 0;
   localparam int IDX_GREEN = 1;
   localparam int IDX_BLUE  = 2;
   localparam int IDX_LUMA  = 0;
   localparam int IDX_CB    = 1;
   localparam int IDX_CR    = 2;

   localparam int MILLI      = 1000;
   localparam int MILLI_HALF = MILLI / 2;

   localparam logic [COLOR_WIDTH-1:0] ALPHA_OPAQUE = '1;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_MATRIX_MODE = 1'b0,
      CSR_SAMPLE_BITS = 1'b1
   } csr_index_type;

   typedef enum logic [MODE_WIDTH-1:0] {
      MODE_BT601 = 2'd0,
      MODE_BT709 = 2'd1,
      MODE_FULL  = 2'd2
   } matrix_mode_type;

   typedef logic [1:0]                    matrix_index_type;
   typedef logic [SAMPLE_WIDTH-1:0]       sample_type;
   typedef logic [COLOR_WIDTH-1:0]        color_type;
   typedef logic signed [DIFF_WIDTH-1:0]  diff_type;
   typedef logic signed [COEF_WIDTH-1:0]  coef_type;
   typedef logic signed [PROD_WIDTH-1:0]  prod_type;
   typedef logic signed [SUM_WIDTH-1:0]   sum_type;
   typedef logic [DIV_WIDTH-1:0]          divisor_type;
   typedef logic [NUM_WIDTH-1:0]          num_type;

   // thousandths to fixed point, ties away from zero
   function automatic coef_type fixed_coef(input int milli);
      int mag;
      int k;
      mag = (milli < 0) ? -milli : milli;
      k   = (mag * (2 ** COEF_FRAC_BITS) + MILLI_HALF) / MILLI;
      return COEF_WIDTH'((milli < 0) ? -k : k);
   endfunction

   // [matrix][color][y,u,v]
   localparam coef_type COEF_TABLE [NUM_MATRICES][NUM_COLORS][NUM_TERMS] = '{
      '{ '{fixed_coef(1164), fixed_coef(0),    fixed_coef(1596)},
         '{fixed_coef(1164), fixed_coef(-392), fixed_coef(-813)},
         '{fixed_coef(1164), fixed_coef(2017), fixed_coef(0)} },
      '{ '{fixed_coef(1164), fixed_coef(0),    fixed_coef(1793)},
         '{fixed_coef(1164), fixed_coef(-213), fixed_coef(-533)},
         '{fixed_coef(1164), fixed_coef(2112), fixed_coef(0)} },
      '{ '{fixed_coef(1000), fixed_coef(0),    fixed_coef(1400)},
         '{fixed_coef(1000), fixed_coef(-343), fixed_coef(-711)},
         '{fixed_coef(1000), fixed_coef(1765), fixed_coef(0)} }
   };

   typedef struct {
      diff_type    diff [NUM_TERMS];
      coef_type    coef [NUM_COLORS][NUM_TERMS];
      divisor_type divisor;
   } front_data_type;

   typedef struct {
      num_type     num [NUM_COLORS];
      divisor_type divisor;
   } scaled_data_type;

   typedef struct {
      color_type color [NUM_COLORS];
   } pixel_data_type;

endpackage

>>> sv/yuvrgb_req_if.sv
// Input channel of the YUV to RGB converter: valid/ready plus one YUV item.
// Depends on yuvrgb_pkg.
interface yuvrgb_req_if;
   import yuvrgb_pkg::*;

   logic       valid;
   logic       ready;
   sample_type luma;
   sample_type chroma_blue;
   sample_type chroma_red;

   modport source (output valid, output luma, output chroma_blue, output chroma_red,
                   input ready);
   modport sink   (input valid, input luma, input chroma_blue, input chroma_red,
                   output ready);
endinterface

>>> sv/yuvrgb_rsp_if.sv
// Result channel of the YUV to RGB converter: valid/ready plus one RGBA item.
// Depends on yuvrgb_pkg.
interface yuvrgb_rsp_if;
   import yuvrgb_pkg::*;

   logic      valid;
   logic      ready;
   color_type red;
   color_type green;
   color_type blue;
   color_type alpha;

   modport source (output valid, output red, output green, output blue, output alpha,
                   input ready);
   modport sink   (input valid, input red, input green, input blue, input alpha,
                   output ready);
endinterface

>>> sv/yuvrgb_front.sv
// Front stage: configuration registers, sample masking, offset removal and
// coefficient selection. Depends on yuvrgb_pkg and the assertion header.
`include "yuv_to_rgb_color_converter_assert.svh"

module yuvrgb_front (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_write_enable,
   input  logic [yuvrgb_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [yuvrgb_pkg::CSR_DATA_WIDTH-1:0]  csr_write_data,
   input  logic                                   in_valid,
   output logic                                   in_ready,
   input  yuvrgb_pkg::sample_type                 in_luma,
   input  yuvrgb_pkg::sample_type                 in_chroma_blue,
   input  yuvrgb_pkg::sample_type                 in_chroma_red,
   output logic                                   out_valid,
   input  logic                                   out_ready,
   output yuvrgb_pkg::front_data_type             out_data
);
   import yuvrgb_pkg::*;

   localparam logic [SHIFT_WIDTH-1:0]  DEPTH_MAX = SHIFT_WIDTH'(MAX_SAMPLE_BITS - MIN_SAMPLE_BITS);
   localparam logic [BITS_WIDTH-1:0]   BITS_MIN  = BITS_WIDTH'(MIN_SAMPLE_BITS);
   localparam logic [BITS_WIDTH-1:0]   BITS_MAX  = BITS_WIDTH'(MAX_SAMPLE_BITS);
   localparam sample_type SAMPLE_ONES      = '1;
   localparam sample_type MID_BASE         = SAMPLE_WIDTH'(2 ** (MIN_SAMPLE_BITS - 1));
   localparam sample_type LUMA_OFFSET_BASE = SAMPLE_WIDTH'(16);

   logic [MODE_WIDTH-1:0] matrix_mode_ff;
   logic [BITS_WIDTH-1:0] sample_bits_ff;
   logic                  valid_ff;
   front_data_type        data_ff;
   front_data_type        data_in;

   logic [BITS_WIDTH-1:0]  bits_eff;
   logic [SHIFT_WIDTH-1:0] depth;
   sample_type             max_value;
   sample_type             mid_value;
   sample_type             luma_offset;
   matrix_index_type       matrix_idx;
   sample_type             luma_m;
   sample_type             cb_m;
   sample_type             cr_m;

   always_ff @(posedge clock) begin
      if (reset) begin
         matrix_mode_ff <= MODE_BT601;
         sample_bits_ff <= BITS_MIN;
      end else if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_MATRIX_MODE: matrix_mode_ff <= csr_write_data[MODE_WIDTH-1:0];
            CSR_SAMPLE_BITS: sample_bits_ff <= csr_write_data[BITS_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      if (sample_bits_ff < BITS_MIN) begin
         bits_eff = BITS_MIN;
      end else if (sample_bits_ff > BITS_MAX) begin
         bits_eff = BITS_MAX;
      end else begin
         bits_eff = sample_bits_ff;
      end
   end

   assign depth     = SHIFT_WIDTH'(bits_eff - BITS_MIN);
   assign max_value = SAMPLE_ONES >> (DEPTH_MAX - depth);
   assign mid_value = MID_BASE << depth;

   always_comb begin
      unique case (matrix_mode_type'(matrix_mode_ff))
         MODE_BT601: matrix_idx = 2'd0;
         MODE_BT709: matrix_idx = 2'd1;
         default:    matrix_idx = 2'd2;
      endcase
   end

   assign luma_offset = (matrix_idx == 2'd2) ? '0 : (LUMA_OFFSET_BASE << depth);
   assign luma_m      = in_luma & max_value;
   assign cb_m        = in_chroma_blue & max_value;
   assign cr_m        = in_chroma_red & max_value;

   always_comb begin
      data_in.diff[IDX_LUMA] = $signed({2'b00, luma_m}) - $signed({2'b00, luma_offset});
      data_in.diff[IDX_CB]   = $signed({2'b00, cb_m}) - $signed({2'b00, mid_value});
      data_in.diff[IDX_CR]   = $signed({2'b00, cr_m}) - $signed({2'b00, mid_value});
      for (int c = 0; c < NUM_COLORS; c++) begin
         for (int t = 0; t < NUM_TERMS; t++) begin
            data_in.coef[c][t] = COEF_TABLE[matrix_idx][c][t];
         end
      end
      data_in.divisor = {max_value, {COEF_FRAC_BITS{1'b0}}};
   end

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   `YUVRGB_ASSERT_NEXT(a_accept_loads, clock, reset, in_valid && in_ready, valid_ff)

endmodule

>>> sv/yuvrgb_mac.sv
// Product-sum pipeline: multiply, add, clamp to full scale and times 255.
// Four register stages. Depends on yuvrgb_pkg and the assertion header.
`include "yuv_to_rgb_color_converter_assert.svh"

module yuvrgb_mac (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   output logic                        in_ready,
   input  yuvrgb_pkg::front_data_type  in_data,
   output logic                        out_valid,
   input  logic                        out_ready,
   output yuvrgb_pkg::scaled_data_type out_data
);
   import yuvrgb_pkg::*;

   typedef struct {
      prod_type    prod [NUM_COLORS][NUM_TERMS];
      divisor_type divisor;
   } prod_stage_type;

   typedef struct {
      sum_type     sum [NUM_COLORS];
      divisor_type divisor;
   } sum_stage_type;

   typedef struct {
      divisor_type value [NUM_COLORS];
      divisor_type divisor;
   } clamp_stage_type;

   logic [3:0]      valid_ff;
   logic [3:0]      stage_ready;
   prod_stage_type  prod_ff, prod_in;
   sum_stage_type   sum_ff, sum_in;
   clamp_stage_type clamp_ff, clamp_in;
   scaled_data_type scaled_ff, scaled_in;

   assign stage_ready[3] = !valid_ff[3] || out_ready;
   assign stage_ready[2] = !valid_ff[2] || stage_ready[3];
   assign stage_ready[1] = !valid_ff[1] || stage_ready[2];
   assign stage_ready[0] = !valid_ff[0] || stage_ready[1];
   assign in_ready       = stage_ready[0];
   assign out_valid      = valid_ff[3];
   assign out_data       = scaled_ff;

   always_comb begin
      for (int c = 0; c < NUM_COLORS; c++) begin
         for (int t = 0; t < NUM_TERMS; t++) begin
            prod_in.prod[c][t] = PROD_WIDTH'(in_data.diff[t]) * PROD_WIDTH'(in_data.coef[c][t]);
         end
      end
      prod_in.divisor = in_data.divisor;
   end

   always_comb begin
      for (int c = 0; c < NUM_COLORS; c++) begin
         sum_in.sum[c] = SUM_WIDTH'(prod_ff.prod[c][IDX_LUMA]) + SUM_WIDTH'(prod_ff.prod[c][IDX_CB])
                       + SUM_WIDTH'(prod_ff.prod[c][IDX_CR]);
      end
      sum_in.divisor = prod_ff.divisor;
   end

   always_comb begin
      for (int c = 0; c < NUM_COLORS; c++) begin
         if (sum_ff.sum[c] < 0) begin
            clamp_in.value[c] = '0;
         end else if (sum_ff.sum[c] > $signed({{(SUM_WIDTH-DIV_WIDTH){1'b0}}, sum_ff.divisor}))
         begin
            clamp_in.value[c] = sum_ff.divisor;
         end else begin
            clamp_in.value[c] = sum_ff.sum[c][DIV_WIDTH-1:0];
         end
      end
      clamp_in.divisor = sum_ff.divisor;
   end

   // x * 255 as x * 256 - x
   always_comb begin
      for (int c = 0; c < NUM_COLORS; c++) begin
         scaled_in.num[c] = {clamp_ff.value[c], {COLOR_WIDTH{1'b0}}}
                          - NUM_WIDTH'(clamp_ff.value[c]);
      end
      scaled_in.divisor = clamp_ff.divisor;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (stage_ready[0]) valid_ff[0] <= in_valid;
         if (stage_ready[1]) valid_ff[1] <= valid_ff[0];
         if (stage_ready[2]) valid_ff[2] <= valid_ff[1];
         if (stage_ready[3]) valid_ff[3] <= valid_ff[2];
      end
   end

   always_ff @(posedge clock) begin
      if (stage_ready[0] && in_valid)    prod_ff   <= prod_in;
      if (stage_ready[1] && valid_ff[0]) sum_ff    <= sum_in;
      if (stage_ready[2] && valid_ff[1]) clamp_ff  <= clamp_in;
      if (stage_ready[3] && valid_ff[2]) scaled_ff <= scaled_in;
   end

   `YUVRGB_ASSERT_HOLDS(a_clamp_in_range, clock, reset, valid_ff[2],
      clamp_ff.value[IDX_RED] <= clamp_ff.divisor &&
      clamp_ff.value[IDX_GREEN] <= clamp_ff.divisor &&
      clamp_ff.value[IDX_BLUE] <= clamp_ff.divisor)

endmodule

>>> sv/yuvrgb_div.sv
// Pipelined restoring divider: one quotient bit per stage, three color lanes.
// Gives floor(num / divisor) in 8 bits. Depends on yuvrgb_pkg and the assertion header.
`include "yuv_to_rgb_color_converter_assert.svh"

module yuvrgb_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   output logic                        in_ready,
   input  yuvrgb_pkg::scaled_data_type in_data,
   output logic                        out_valid,
   input  logic                        out_ready,
   output yuvrgb_pkg::pixel_data_type  out_data
);
   import yuvrgb_pkg::*;

   localparam int LAST = COLOR_WIDTH - 1;

   typedef struct {
      num_type     rem [NUM_COLORS];
      color_type   quo [NUM_COLORS];
      divisor_type divisor;
   } div_stage_type;

   logic [COLOR_WIDTH-1:0] valid_ff;
   logic [COLOR_WIDTH-1:0] stage_ready;
   div_stage_type          stage_ff [COLOR_WIDTH];
   div_stage_type          stage_in [COLOR_WIDTH];
   logic [COLOR_WIDTH-1:0] src_valid;

   for (genvar i = 0; i < COLOR_WIDTH; i++) begin : g_stage
      localparam int BIT = COLOR_WIDTH - 1 - i;
      div_stage_type src;

      if (i == 0) begin : g_first
         always_comb begin
            for (int c = 0; c < NUM_COLORS; c++) begin
               src.rem[c] = in_data.num[c];
               src.quo[c] = '0;
            end
            src.divisor = in_data.divisor;
         end
         assign src_valid[i] = in_valid;
      end else begin : g_next
         assign src          = stage_ff[i-1];
         assign src_valid[i] = valid_ff[i-1];
      end

      if (i == LAST) begin : g_out
         assign stage_ready[i] = !valid_ff[i] || out_ready;
      end else begin : g_mid
         assign stage_ready[i] = !valid_ff[i] || stage_ready[i+1];
      end

      always_comb begin
         for (int c = 0; c < NUM_COLORS; c++) begin
            if (src.rem[c] >= (NUM_WIDTH'(src.divisor) << BIT)) begin
               stage_in[i].rem[c] = src.rem[c] - (NUM_WIDTH'(src.divisor) << BIT);
               stage_in[i].quo[c] = src.quo[c] | (COLOR_WIDTH'(1) << BIT);
            end else begin
               stage_in[i].rem[c] = src.rem[c];
               stage_in[i].quo[c] = src.quo[c];
            end
         end
         stage_in[i].divisor = src.divisor;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i] <= 1'b0;
         end else if (stage_ready[i]) begin
            valid_ff[i] <= src_valid[i];
         end
      end

      always_ff @(posedge clock) begin
         if (stage_ready[i] && src_valid[i]) begin
            stage_ff[i] <= stage_in[i];
         end
      end
   end

   assign in_ready  = stage_ready[0];
   assign out_valid = valid_ff[LAST];

   always_comb begin
      for (int c = 0; c < NUM_COLORS; c++) begin
         out_data.color[c] = stage_ff[LAST].quo[c];
      end
   end

   `YUVRGB_ASSERT_HOLDS(a_rem_below_divisor, clock, reset, valid_ff[LAST],
      stage_ff[LAST].rem[IDX_RED] < NUM_WIDTH'(stage_ff[LAST].divisor) &&
      stage_ff[LAST].rem[IDX_GREEN] < NUM_WIDTH'(stage_ff[LAST].divisor) &&
      stage_ff[LAST].rem[IDX_BLUE] < NUM_WIDTH'(stage_ff[LAST].divisor))

endmodule

>>> sv/yuv_to_rgb_color_converter.sv
// YUV to RGB color converter, top level.
// Channels: req_chan takes one Y, Cb, Cr item of sample_bits bits per sample
// (8 to 16, low bits of each 16-bit field); rsp_chan returns 8-bit red,
// green, blue and an alpha of 255. Both use valid/ready; an item moves on a
// clock edge with valid and ready high.
// Registers: csr index 0 picks the matrix (BT.601 limited, BT.709 limited,
// full range), index 1 sets sample_bits. Write them only while no item is
// in flight.
// Stages: 1 front stage, 4 multiply/sum/clamp/scale stages and 8 divider
// stages, one quotient bit each. Throughput: one item per clock while the
// receiver takes results from rsp_chan.
// Each stage holds its item while the next is full, so a stalled receiver
// backs the pipeline up without loss; bubbles are squeezed out, so items are
// still taken while a result waits. Reset empties the pipeline, sets mode
// BT.601 and sample_bits 8.
// Depends on yuvrgb_pkg, yuvrgb_req_if, yuvrgb_rsp_if and the stage modules.
module yuv_to_rgb_color_converter (
   input  logic                                   clock,
   input  logic                                   reset,
   yuvrgb_req_if.sink                             req_chan,
   yuvrgb_rsp_if.source                           rsp_chan,
   input  logic                                   csr_write_enable,
   input  logic [yuvrgb_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [yuvrgb_pkg::CSR_DATA_WIDTH-1:0]  csr_write_data
);
   import yuvrgb_pkg::*;

   logic            front_valid;
   logic            front_ready;
   front_data_type  front_data;
   logic            mac_valid;
   logic            mac_ready;
   scaled_data_type mac_data;
   pixel_data_type  pixel_data;

   yuvrgb_front u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .in_valid         (req_chan.valid),
      .in_ready         (req_chan.ready),
      .in_luma          (req_chan.luma),
      .in_chroma_blue   (req_chan.chroma_blue),
      .in_chroma_red    (req_chan.chroma_red),
      .out_valid        (front_valid),
      .out_ready        (front_ready),
      .out_data         (front_data)
   );

   yuvrgb_mac u_mac (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_ready  (front_ready),
      .in_data   (front_data),
      .out_valid (mac_valid),
      .out_ready (mac_ready),
      .out_data  (mac_data)
   );

   yuvrgb_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (mac_valid),
      .in_ready  (mac_ready),
      .in_data   (mac_data),
      .out_valid (rsp_chan.valid),
      .out_ready (rsp_chan.ready),
      .out_data  (pixel_data)
   );

   assign rsp_chan.red   = pixel_data.color[IDX_RED];
   assign rsp_chan.green = pixel_data.color[IDX_GREEN];
   assign rsp_chan.blue  = pixel_data.color[IDX_BLUE];
   assign rsp_chan.alpha = ALPHA_OPAQUE;

endmodule
